### rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and codes of the rectangle fill/copy mover
// Item operation codes, register indexes and the command record that travels
// from the front queue to the execution engine.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int unsigned PixW    = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned LineW   = 14;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgW    = 32;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BEAT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COPY_MODE    = 4'd0,
    REG_FILL_COLOR   = 4'd1,
    REG_SOURCE_START = 4'd2,
    REG_DEST_START   = 4'd3,
    REG_SOURCE_SKIP  = 4'd4,
    REG_DEST_SKIP    = 4'd5,
    REG_LINE_PIXELS  = 4'd6,
    REG_LINE_TOTAL   = 4'd7
  } reg_e;

  typedef struct packed {
    op_e             kind;
    logic [PixW-1:0] fetched;
  } cmd_t;

endpackage

### rtl/rfc_front.sv
// ----------------------------------------------------------------------------
// rfc_front: item intake and command queue
// Decodes each accepted item into a command and holds it in a two-entry
// queue, so intake keeps going while the engine waits on its output.
// ----------------------------------------------------------------------------
module rfc_front
  import rfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [PixW-1:0]  fetched_pixel_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.fetched = fetched_pixel_i;
    cmd_in.kind    = op_e'(op_i);
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cmd_in;
  end

endmodule

### rtl/rfc_back.sv
// ----------------------------------------------------------------------------
// rfc_back: transfer engine
// Holds the register file and walk state, executes one command a cycle unless
// its registered result is held untaken, which stalls the command queue.
// ----------------------------------------------------------------------------
module rfc_back
  import rfc_pkg::*;
#(
  parameter int unsigned PIXEL_BYTES = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_t               cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               write_valid_o,
  output logic [AddrW-1:0]   write_address_o,
  output logic [PixW-1:0]    write_pixel_o,
  output logic [AddrW-1:0]   next_read_address_o,
  output logic               engine_busy_o,
  output logic               transfer_done_o,
  output logic               final_pixel_o
);

  localparam logic [AddrW-1:0] PixStep = AddrW'(PIXEL_BYTES);

  // register file
  logic              copy_mode_q;
  logic [PixW-1:0]   fill_color_q;
  logic [AddrW-1:0]  source_start_q, dest_start_q;
  logic [LineW-1:0]  source_skip_q, dest_skip_q, line_pixels_q;
  logic [CountW-1:0] line_total_q;

  // walk state
  logic              busy_q, busy_d, done_q, done_d;
  logic [AddrW-1:0]  src_q, src_d, dst_q, dst_d;
  logic [LineW-1:0]  pil_q, pil_d, pil_inc;
  logic [CountW-1:0] ld_q, ld_d, ld_inc;
  logic [AddrW-1:0]  src_line_step, dst_line_step;

  // result
  logic              out_valid_q;
  logic              wv_d, wv_q, fin_d, fin_q;
  logic [AddrW-1:0]  waddr_d, waddr_q, raddr_d, raddr_q;
  logic [PixW-1:0]   wpix_d, wpix_q;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_mode_q    <= 1'b0;
      fill_color_q   <= '0;
      source_start_q <= '0;
      dest_start_q   <= '0;
      source_skip_q  <= '0;
      dest_skip_q    <= '0;
      line_pixels_q  <= '0;
      line_total_q   <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_COPY_MODE:    copy_mode_q    <= cfg_data_i[0];
        REG_FILL_COLOR:   fill_color_q   <= cfg_data_i[PixW-1:0];
        REG_SOURCE_START: source_start_q <= cfg_data_i[AddrW-1:0];
        REG_DEST_START:   dest_start_q   <= cfg_data_i[AddrW-1:0];
        REG_SOURCE_SKIP:  source_skip_q  <= cfg_data_i[LineW-1:0];
        REG_DEST_SKIP:    dest_skip_q    <= cfg_data_i[LineW-1:0];
        REG_LINE_PIXELS:  line_pixels_q  <= cfg_data_i[LineW-1:0];
        REG_LINE_TOTAL:   line_total_q   <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign src_line_step = PixStep * (AddrW'(source_skip_q) + AddrW'(1));
  assign dst_line_step = PixStep * (AddrW'(dest_skip_q) + AddrW'(1));
  assign pil_inc       = pil_q + LineW'(1);
  assign ld_inc        = ld_q + CountW'(1);

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    busy_d  = busy_q;
    done_d  = done_q;
    src_d   = src_q;
    dst_d   = dst_q;
    pil_d   = pil_q;
    ld_d    = ld_q;
    wv_d    = 1'b0;
    waddr_d = '0;
    wpix_d  = '0;
    fin_d   = 1'b0;
    case (cmd_i.kind)
      OP_START: begin
        // a start while running is dropped
        if (!busy_q) begin
          src_d = source_start_q;
          dst_d = dest_start_q;
          pil_d = '0;
          ld_d  = '0;
          if (line_pixels_q == '0 || line_total_q == '0) begin
            done_d = 1'b1;
          end else begin
            busy_d = 1'b1;
          end
        end
      end
      OP_BEAT: begin
        if (busy_q) begin
          wv_d    = 1'b1;
          waddr_d = dst_q;
          wpix_d  = copy_mode_q ? cmd_i.fetched : fill_color_q;
          // wrap of the counter also ends the line
          if (pil_inc == '0 || pil_inc >= line_pixels_q) begin
            pil_d = '0;
            ld_d  = ld_inc;
            dst_d = dst_q + dst_line_step;
            src_d = src_q + src_line_step;
            if (ld_inc == '0 || ld_inc >= line_total_q) begin
              busy_d = 1'b0;
              done_d = 1'b1;
              fin_d  = 1'b1;
            end
          end else begin
            pil_d = pil_inc;
            dst_d = dst_q + PixStep;
            src_d = src_q + PixStep;
          end
        end
      end
      OP_CLEAR: done_d = 1'b0;
      default: ;
    endcase
    raddr_d = (busy_d && copy_mode_q) ? src_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      src_q       <= '0;
      dst_q       <= '0;
      pil_q       <= '0;
      ld_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        busy_q <= busy_d;
        done_q <= done_d;
        src_q  <= src_d;
        dst_q  <= dst_d;
        pil_q  <= pil_d;
        ld_q   <= ld_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      wv_q    <= wv_d;
      waddr_q <= waddr_d;
      wpix_q  <= wpix_d;
      raddr_q <= raddr_d;
      fin_q   <= fin_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign write_valid_o       = wv_q;
  assign write_address_o     = waddr_q;
  assign write_pixel_o       = wpix_q;
  assign next_read_address_o = raddr_q;
  assign engine_busy_o       = busy_q;
  assign transfer_done_o     = done_q;
  assign final_pixel_o       = fin_q;

  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fin_q |-> wv_q && done_q && !busy_q)
    else $error("final pixel without completion");

  a_idle_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cmd_i.kind == OP_BEAT && !busy_q |=> !wv_q && !busy_q)
    else $error("beat while idle produced a write");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !wv_q |-> waddr_q == '0 && wpix_q == '0 && !fin_q)
    else $error("write fields set without a write");

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cmd_i.kind == OP_START && !busy_q |=> busy_q || done_q)
    else $error("start left engine neither busy nor done");

endmodule

### rtl/rect_fill_copy_dma_core.sv
// ----------------------------------------------------------------------------
// rect_fill_copy_dma_core: two-dimensional RGB565 fill/copy mover
// Top level: item queue in front, transfer engine with registered result.
// ----------------------------------------------------------------------------
// The mover takes one item per clock while its output is taken, and returns
// exactly one result per item. An accepted item is written into a two-entry
// command queue, is executed when the engine pops it, and its result is held
// in the engine's result register until it is taken. The engine updates its
// pointers and counters with one 32-bit add per address and stalls only while
// its result is held, so the sustained rate is one item per clock. The user
// must write registers through the configuration port only while no item or
// result is in flight; the block itself does not enforce this. A running
// transfer picks up the new values at once.
module rect_fill_copy_dma_core
  import rfc_pkg::*;
#(
  parameter int unsigned PIXEL_BYTES = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [PixW-1:0]    fetched_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               write_valid_o,
  output logic [AddrW-1:0]   write_address_o,
  output logic [PixW-1:0]    write_pixel_o,
  output logic [AddrW-1:0]   next_read_address_o,
  output logic               engine_busy_o,
  output logic               transfer_done_o,
  output logic               final_pixel_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  rfc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .fetched_pixel_i (fetched_pixel_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  rfc_back #(
    .PIXEL_BYTES (PIXEL_BYTES)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .cmd_valid_i         (cmd_valid),
    .cmd_ready_o         (cmd_ready),
    .cmd_i               (cmd),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .write_valid_o       (write_valid_o),
    .write_address_o     (write_address_o),
    .write_pixel_o       (write_pixel_o),
    .next_read_address_o (next_read_address_o),
    .engine_busy_o       (engine_busy_o),
    .transfer_done_o     (transfer_done_o),
    .final_pixel_o       (final_pixel_o)
  );

endmodule
